FILE: hdl/lru_writeback_block_cache_ctrl_top_defines.svh
// Assertion helpers shared by the block-cache controller files.
`ifndef LRU_WRITEBACK_BLOCK_CACHE_CTRL_TOP_DEFINES_SVH
`define LRU_WRITEBACK_BLOCK_CACHE_CTRL_TOP_DEFINES_SVH

// Checks that a condition holds at every clock edge out of reset.
`define LWB_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a consequence holds in the cycle after its trigger.
`define LWB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/lwbcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbcc_pkg
// Shared constants and control types of the block-cache controller.
// ----------------------------------------------------------------------------
package lwbcc_pkg;

  localparam int NUM_BUFS        = 16;
  localparam int BLOCK_ADDR_BITS = 31;
  localparam int MAX_RESULTS     = 16;
  localparam int SLOT_W          = $clog2(NUM_BUFS);
  localparam int CNT_W           = $clog2(NUM_BUFS + 1);
  localparam int CUR_W           = $clog2(MAX_RESULTS);
  localparam int BLK_PORT_W      = 31;
  localparam int SLOT_PORT_W     = 4;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_SYNC  = 2'd2;
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  typedef struct packed {
    logic load;
    logic access;
    logic sync_step;
    logic sync_last;
    logic null_op;
  } lwbcc_ctrl_t;

  typedef struct packed {
    logic [1:0]       cmd_code;
    logic             out_free;
    logic [CNT_W-1:0] ndirty;
  } lwbcc_stat_t;

endpackage

FILE: hdl/lwbcc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbcc_datapath
// Slot tags, valid and dirty bits, LRU ranks, dirty order and result register.
// ----------------------------------------------------------------------------
`include "lru_writeback_block_cache_ctrl_top_defines.svh"
module lwbcc_datapath
  import lwbcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             cmd,
  input  logic [BLK_PORT_W-1:0]  block_number,
  input  lwbcc_ctrl_t            ctrl,
  output lwbcc_stat_t            stat,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   hit,
  output logic [SLOT_PORT_W-1:0] slot,
  output logic                   fetch_needed,
  output logic                   writeback_valid,
  output logic [BLK_PORT_W-1:0]  writeback_block,
  output logic                   last
);

  logic [1:0]                 cmd_q;
  logic [BLOCK_ADDR_BITS-1:0] blk_q;
  logic [BLOCK_ADDR_BITS-1:0] block_tag [NUM_BUFS];
  logic [NUM_BUFS-1:0]        slot_valid;
  logic [NUM_BUFS-1:0]        slot_dirty;
  logic [SLOT_W-1:0]          lru_rank [NUM_BUFS];
  logic [SLOT_W-1:0]          dirty_order [NUM_BUFS];
  logic [CNT_W-1:0]           occupancy;

  logic              hit_w, full, is_write, sdirty;
  logic              found_hit, found_free, found_vic, found_sync;
  logic [SLOT_W-1:0] hit_s, free_s, vic_s, sync_s, acc_s;
  logic [SLOT_W-1:0] r_sel, d_sel;
  logic [CNT_W-1:0]  ndirty;

  assign full     = (occupancy == CNT_W'(NUM_BUFS));
  assign is_write = (cmd_q == CMD_WRITE);
  assign ndirty   = CNT_W'($countones(slot_dirty));

  always_comb begin
    found_hit  = 1'b0;
    found_free = 1'b0;
    found_vic  = 1'b0;
    found_sync = 1'b0;
    hit_s      = '0;
    free_s     = '0;
    vic_s      = '0;
    sync_s     = '0;
    for (int i = 0; i < NUM_BUFS; i++) begin
      if (!found_hit && slot_valid[i] && block_tag[i] == blk_q) begin
        found_hit = 1'b1;
        hit_s     = SLOT_W'(i);
      end
      if (!found_free && !slot_valid[i]) begin
        found_free = 1'b1;
        free_s     = SLOT_W'(i);
      end
      if (!found_vic && slot_valid[i] && lru_rank[i] == '0) begin
        found_vic = 1'b1;
        vic_s     = SLOT_W'(i);
      end
      if (!found_sync && slot_dirty[i] && dirty_order[i] == '0) begin
        found_sync = 1'b1;
        sync_s     = SLOT_W'(i);
      end
    end
  end

  assign hit_w  = found_hit;
  assign acc_s  = hit_w ? hit_s : (full ? vic_s : free_s);
  assign r_sel  = lru_rank[acc_s];
  assign d_sel  = dirty_order[acc_s];
  assign sdirty = slot_dirty[acc_s];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= cmd;
      blk_q <= block_number[BLOCK_ADDR_BITS-1:0];
    end
    if (ctrl.access && !hit_w) begin
      block_tag[acc_s] <= blk_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_dirty <= '0;
      occupancy  <= '0;
      for (int i = 0; i < NUM_BUFS; i++) begin
        lru_rank[i]    <= '0;
        dirty_order[i] <= '0;
      end
    end else if (ctrl.access) begin
      for (int i = 0; i < NUM_BUFS; i++) begin
        if (SLOT_W'(i) != acc_s) begin
          if ((hit_w || full) && slot_valid[i] && lru_rank[i] > r_sel) begin
            lru_rank[i] <= lru_rank[i] - 1'b1;
          end
          if (!hit_w && full && sdirty && slot_dirty[i] && dirty_order[i] > d_sel) begin
            dirty_order[i] <= dirty_order[i] - 1'b1;
          end
        end
      end
      if (hit_w) begin
        lru_rank[acc_s] <= SLOT_W'(occupancy - 1'b1);
        if (is_write && !sdirty) begin
          slot_dirty[acc_s]  <= 1'b1;
          dirty_order[acc_s] <= SLOT_W'(ndirty);
        end
      end else if (!full) begin
        slot_valid[acc_s]  <= 1'b1;
        lru_rank[acc_s]    <= SLOT_W'(occupancy);
        slot_dirty[acc_s]  <= is_write;
        dirty_order[acc_s] <= is_write ? SLOT_W'(ndirty) : '0;
        occupancy          <= occupancy + 1'b1;
      end else begin
        lru_rank[acc_s]    <= SLOT_W'(occupancy - 1'b1);
        slot_dirty[acc_s]  <= is_write;
        dirty_order[acc_s] <= is_write ? SLOT_W'(ndirty - CNT_W'(sdirty)) : '0;
      end
    end else if (ctrl.sync_step) begin
      for (int i = 0; i < NUM_BUFS; i++) begin
        if (SLOT_W'(i) != sync_s && slot_dirty[i] && dirty_order[i] != '0) begin
          dirty_order[i] <= dirty_order[i] - 1'b1;
        end
      end
      slot_dirty[sync_s]  <= 1'b0;
      dirty_order[sync_s] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.access || ctrl.sync_step || ctrl.null_op) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.access) begin
      hit             <= hit_w;
      slot            <= SLOT_PORT_W'(acc_s);
      fetch_needed    <= !hit_w && (cmd_q == CMD_READ);
      writeback_valid <= !hit_w && full && sdirty;
      writeback_block <= (!hit_w && full && sdirty) ? BLK_PORT_W'(block_tag[acc_s]) : '0;
      last            <= 1'b1;
    end else if (ctrl.sync_step) begin
      hit             <= 1'b0;
      slot            <= SLOT_PORT_W'(sync_s);
      fetch_needed    <= 1'b0;
      writeback_valid <= 1'b1;
      writeback_block <= BLK_PORT_W'(block_tag[sync_s]);
      last            <= ctrl.sync_last;
    end else if (ctrl.null_op) begin
      hit             <= 1'b0;
      slot            <= '0;
      fetch_needed    <= 1'b0;
      writeback_valid <= 1'b0;
      writeback_block <= '0;
      last            <= 1'b1;
    end
  end

  assign stat.cmd_code = cmd_q;
  assign stat.out_free = !out_valid || !out_stall;
  assign stat.ndirty   = ndirty;

  `LWB_ASSERT_ALWAYS(a_occ_range, occupancy <= CNT_W'(NUM_BUFS), "occupancy overflow")
  `LWB_ASSERT_ALWAYS(a_dirty_valid, (slot_dirty & ~slot_valid) == '0, "dirty slot not valid")
  `LWB_ASSERT_ALWAYS(a_occ_count, CNT_W'($countones(slot_valid)) == occupancy, "occupancy mismatch")
  `LWB_ASSERT_NEXT(a_fill_grows, ctrl.access && !hit_w && !full, occupancy == $past(occupancy) + 1'b1, "fill did not grow occupancy")

endmodule

FILE: hdl/lwbcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbcc_ctrl
// Sequencer for item intake, lookup and the sync write-back walk.
// ----------------------------------------------------------------------------
module lwbcc_ctrl
  import lwbcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  lwbcc_stat_t stat,
  output lwbcc_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SYNC = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [CUR_W-1:0] cursor, cursor_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cursor_next    = cursor;
    ctrl           = '0;
    ctrl.sync_last = (stat.ndirty == CNT_W'(1)) || (cursor == CUR_W'(MAX_RESULTS - 1));
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.cmd_code == CMD_SYNC) begin
          cursor_next = '0;
          state_next  = S_SYNC;
        end else if (stat.out_free) begin
          if (stat.cmd_code == CMD_UNDEF) begin
            ctrl.null_op = 1'b1;
          end else begin
            ctrl.access = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_SYNC: begin
        if (stat.out_free) begin
          if (stat.ndirty == '0) begin
            ctrl.null_op = 1'b1;
            state_next   = S_IDLE;
          end else begin
            ctrl.sync_step = 1'b1;
            cursor_next    = cursor + 1'b1;
            if (ctrl.sync_last) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cursor <= '0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
    end
  end

endmodule

FILE: hdl/lru_writeback_block_cache_ctrl_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_ctrl_top
// Fully associative LRU write-back block-cache controller.
//
// The input channel (in_valid, in_stall) carries one command item: read,
// write or sync of a block number. The output channel (out_valid, out_stall)
// carries result items; the last result of an item has last set.
// A read or write first captures the item, then does the parallel tag match
// and the LRU and dirty order update and registers its result. A sync emits
// one write-back per dirty slot, oldest first, one per cycle while the output
// is not stalled, after a setup step; when no slot is dirty it emits a single
// result with no write-back. An item is taken only after the previous one has
// issued all of its results.
// Results sit in an output register; a stall on the output holds it and
// pauses the controller until the register frees up. A synchronous reset
// empties all slots and the output register.
// ----------------------------------------------------------------------------
module lru_writeback_block_cache_ctrl_top
  import lwbcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             cmd,
  input  logic [BLK_PORT_W-1:0]  block_number,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   hit,
  output logic [SLOT_PORT_W-1:0] slot,
  output logic                   fetch_needed,
  output logic                   writeback_valid,
  output logic [BLK_PORT_W-1:0]  writeback_block,
  output logic                   last
);

  lwbcc_ctrl_t ctrl;
  lwbcc_stat_t stat;

  lwbcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  lwbcc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .block_number    (block_number),
    .ctrl            (ctrl),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .slot            (slot),
    .fetch_needed    (fetch_needed),
    .writeback_valid (writeback_valid),
    .writeback_block (writeback_block),
    .last            (last)
  );

endmodule
